>>> hdl/lsp_pkg.sv
// Shared types, constants and pattern tables for the line sensor PID block.
`default_nettype none
package lsp_pkg;

  localparam int SENSOR_W = 8;
  localparam int ERR_W    = 14;
  localparam int GAIN_W   = 16;
  localparam int DRIVE_W  = 24;
  localparam int CFG_IDX_W = 2;

  localparam int DIVD_W   = 16;
  localparam int DIVS_W   = 4;
  localparam int DIV_BITS = 2;
  localparam int DIV_STEPS = DIVD_W / DIV_BITS;

  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 24'sh7FFFFF;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -24'sh800000;
  localparam logic signed [ERR_W-1:0] ERR_LIMIT = 14'sd7680;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_P_GAIN = 2'd0;
  localparam cfg_idx_t REG_I_GAIN = 2'd1;
  localparam cfg_idx_t REG_D_GAIN = 2'd2;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  typedef struct packed {
    logic                    hit;
    logic signed [ERR_W-1:0] value;
  } table_hit_t;

  function automatic table_hit_t fixed_lookup(input logic [SENSOR_W-1:0] bits);
    table_hit_t r;
    r.hit = 1'b1;
    case (bits)
      8'h18, 8'h3C: r.value = 14'sd0;
      8'h08, 8'h0C, 8'h1E: r.value = 14'sd1920;
      8'h20, 8'h30, 8'h78: r.value = -14'sd1920;
      8'h02, 8'h06: r.value = 14'sd3200;
      8'h40, 8'h60, 8'h0F, 8'hF0: r.value = -14'sd3200;
      8'h01: r.value = 14'sd6400;
      8'h80: r.value = -14'sd6400;
      8'h03: r.value = 14'sd5120;
      8'hC0: r.value = -14'sd5120;
      8'h1C: r.value = 14'sd1024;
      8'h38: r.value = -14'sd1024;
      8'h0E: r.value = 14'sd2560;
      8'h70: r.value = -14'sd2560;
      8'h07: r.value = 14'sd4096;
      8'hE0: r.value = -14'sd4096;
      default: begin
        r.hit   = 1'b0;
        r.value = 14'sd0;
      end
    endcase
    return r;
  endfunction

  // Weight per bit number, bit 7 is the leftmost sensor.
  function automatic logic signed [4:0] bit_weight(input logic [2:0] idx);
    logic signed [4:0] w;
    case (idx)
      3'd0: w = 5'sd6;
      3'd1: w = 5'sd4;
      3'd2: w = 5'sd2;
      3'd3: w = 5'sd1;
      3'd4: w = -5'sd1;
      3'd5: w = -5'sd2;
      3'd6: w = -5'sd4;
      3'd7: w = -5'sd6;
      default: w = 5'sd0;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

>>> hdl/lsp_in_if.sv
// Sample input channel: one sensor pattern per transaction.
`default_nettype none
interface lsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] sensor_bits;
  modport source (output valid, output sensor_bits, input ready);
  modport sink   (input valid, input sensor_bits, output ready);
endinterface
`default_nettype wire

>>> hdl/lsp_out_if.sv
// Result channel: line error, drive value and line-lost flag per transaction.
`default_nettype none
interface lsp_out_if;
  logic               valid;
  logic               ready;
  logic signed [13:0] line_error;
  logic signed [23:0] drive_value;
  logic               line_lost;
  modport source (output valid, output line_error, output drive_value, output line_lost,
                  input ready);
  modport sink   (input valid, input line_error, input drive_value, input line_lost,
                  output ready);
endinterface
`default_nettype wire

>>> hdl/lsp_cfg_if.sv
// Configuration write channel: register index and write data.
`default_nettype none
interface lsp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/lsp_div.sv
// Radix-4 restoring divider for the sensor centroid, two quotient bits per cycle.
`default_nettype none
module lsp_div (
  input  logic                       clk,
  input  logic                       rst,
  input  lsp_pkg::div_ctl_t          ctl,
  input  logic [lsp_pkg::DIVD_W-1:0] dividend,
  input  logic [lsp_pkg::DIVS_W-1:0] divisor,
  output logic [lsp_pkg::DIVD_W-1:0] quotient,
  output lsp_pkg::div_sts_t          sts
);
  import lsp_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [DIVD_W-1:0] quo;
  logic [DIVS_W-1:0] rem;
  logic [DIVS_W-1:0] dvs;
  logic [DIVD_W-1:0] quo_next;
  logic [DIVS_W-1:0] rem_next;
  logic [DIVS_W:0]   trial;

  always_comb begin
    quo_next = quo;
    rem_next = rem;
    trial    = '0;
    for (int s = 0; s < DIV_BITS; s++) begin
      trial    = {rem_next, quo_next[DIVD_W-1]};
      quo_next = {quo_next[DIVD_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        trial       = trial - {1'b0, dvs};
        quo_next[0] = 1'b1;
      end
      rem_next = trial[DIVS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient = quo;
  assign sts.busy = busy;
  assign sts.done = done;

  a_no_restart: assert property (@(posedge clk) disable iff (rst) ctl.start |-> !busy)
    else $error("divider restarted while busy");
  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("divider done without a running division");

endmodule
`default_nettype wire

>>> hdl/line_sensor_pid.sv
// Top level of the line sensor PID block.
// Each sensor transaction yields one result transaction. Listed patterns and the all-dark
// pattern go through S_MP, S_MI, S_MD and S_ACC to S_OUT, which registers the result once
// the output is free, then back to S_IDLE for the next sample; other patterns pass through
// the 8-iteration radix-4 divider (S_DIV) first. The three gain products share one 16-bit
// by window-sum-wide multiplier, one product per cycle. The input is not ready while a
// sample is in work; a finished result waits in the output register until taken.
// Gain writes are always ready; an index beyond the gain list is ignored.
`default_nettype none
module line_sensor_pid #(
  parameter int WINDOW_DEPTH = 5
) (
  input  logic clk,
  input  logic rst,
  lsp_cfg_if.sink   cfg,
  lsp_in_if.sink    sample,
  lsp_out_if.source result
);
  import lsp_pkg::*;

  localparam int WSUM_W = ERR_W + $clog2(WINDOW_DEPTH);
  localparam int MB_W   = (WSUM_W > ERR_W + 1) ? WSUM_W : ERR_W + 1;
  localparam int PROD_W = GAIN_W + MB_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int SH_W   = ACC_W - 8;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_MP, S_MI, S_MD, S_ACC, S_OUT
  } state_t;

  state_t state;

  logic signed [GAIN_W-1:0] p_gain;
  logic signed [GAIN_W-1:0] i_gain;
  logic signed [GAIN_W-1:0] d_gain;

  logic signed [ERR_W-1:0]  last_error;
  logic signed [ERR_W-1:0]  err_win [WINDOW_DEPTH];
  logic signed [WSUM_W-1:0] win_sum;
  logic signed [WSUM_W-1:0] win_sum_next;

  logic signed [ERR_W-1:0]  err;
  logic                     lost;
  logic                     neg;
  logic signed [ERR_W:0]    diff;

  logic signed [GAIN_W-1:0] mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [SH_W-1:0]   acc_sh;
  logic signed [DRIVE_W-1:0] drive_sat;

  table_hit_t               hit;
  logic signed [4:0]        wsum;
  logic [3:0]               count;
  logic signed [DIVD_W-1:0] num;
  logic [DIVD_W-1:0]        num_mag;
  logic [DIVD_W-1:0]        quotient;
  logic signed [ERR_W-1:0]  quo_err;
  div_ctl_t                 div_ctl;
  div_sts_t                 div_sts;
  logic                     take;
  logic                     out_free;

  assign cfg.ready    = 1'b1;
  assign sample.ready = (state == S_IDLE);
  assign take         = sample.valid && sample.ready;
  assign out_free     = !result.valid || result.ready;

  // Centroid numerator: 5 * 256 * weighted sum.
  always_comb begin
    hit   = fixed_lookup(sample.sensor_bits);
    wsum  = '0;
    count = '0;
    for (int b = 0; b < SENSOR_W; b++) begin
      if (sample.sensor_bits[b]) begin
        wsum  = wsum + bit_weight(3'(b));
        count = count + 4'd1;
      end
    end
    num     = (DIVD_W'(wsum) <<< 10) + (DIVD_W'(wsum) <<< 8);
    num_mag = num[DIVD_W-1] ? DIVD_W'(-num) : DIVD_W'(num);
  end

  assign div_ctl.start = take && (sample.sensor_bits != '0) && !hit.hit;

  lsp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (num_mag),
    .divisor  (count),
    .quotient (quotient),
    .sts      (div_sts)
  );

  assign quo_err      = ERR_W'(quotient);
  assign win_sum_next = win_sum - WSUM_W'(err_win[0]) + WSUM_W'(err);
  assign diff         = (ERR_W + 1)'(err) - (ERR_W + 1)'(last_error);

  always_comb begin
    case (state)
      S_MP: begin
        mul_a = p_gain;
        mul_b = MB_W'(err);
      end
      S_MI: begin
        mul_a = i_gain;
        mul_b = MB_W'(win_sum_next);
      end
      default: begin
        mul_a = d_gain;
        mul_b = MB_W'(diff);
      end
    endcase
  end

  always_comb begin
    acc_sh = SH_W'(acc >>> 8);
    if (acc_sh > SH_W'(DRIVE_MAX)) begin
      drive_sat = DRIVE_MAX;
    end else if (acc_sh < SH_W'(DRIVE_MIN)) begin
      drive_sat = DRIVE_MIN;
    end else begin
      drive_sat = DRIVE_W'(acc_sh);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_gain <= '0;
      i_gain <= '0;
      d_gain <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_P_GAIN: p_gain <= cfg.data;
        REG_I_GAIN: i_gain <= cfg.data;
        REG_D_GAIN: d_gain <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result.valid <= 1'b0;
      last_error   <= '0;
      win_sum      <= '0;
      for (int k = 0; k < WINDOW_DEPTH; k++) begin
        err_win[k] <= '0;
      end
    end else begin
      if (result.valid && result.ready && state != S_OUT) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            lost <= (sample.sensor_bits == '0);
            neg  <= num[DIVD_W-1];
            if (sample.sensor_bits == '0) begin
              err   <= last_error;
              state <= S_MP;
            end else if (hit.hit) begin
              err   <= hit.value;
              state <= S_MP;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_sts.done) begin
            err   <= neg ? -quo_err : quo_err;
            state <= S_MP;
          end
        end
        S_MP: begin
          prod  <= mul_a * mul_b;
          state <= S_MI;
        end
        S_MI: begin
          prod  <= mul_a * mul_b;
          acc   <= ACC_W'(prod);
          state <= S_MD;
        end
        S_MD: begin
          prod  <= mul_a * mul_b;
          acc   <= acc + ACC_W'(prod);
          state <= S_ACC;
        end
        S_ACC: begin
          acc   <= acc + ACC_W'(prod);
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            result.valid       <= 1'b1;
            result.line_error  <= err;
            result.drive_value <= drive_sat;
            result.line_lost   <= lost;
            last_error         <= err;
            win_sum            <= win_sum_next;
            for (int k = 0; k < WINDOW_DEPTH - 1; k++) begin
              err_win[k] <= err_win[k + 1];
            end
            err_win[WINDOW_DEPTH - 1] <= err;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_lost_holds: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.line_lost |-> result.line_error == last_error)
    else $error("held error differs from last error");
  a_err_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.line_error <= ERR_LIMIT && result.line_error >= -ERR_LIMIT)
    else $error("line error out of range");
  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    div_sts.busy || div_sts.done |-> state == S_DIV)
    else $error("divider running outside its state");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    take |=> !sample.ready)
    else $error("second sample taken while one is in work");

endmodule
`default_nettype wire
